[hdl/sfr_pkg.sv]
// Shared constants and types for the stream find-and-replace block.
`default_nettype none

package sfr_pkg;

   // Bounds on pattern and replacement length, in bytes
   localparam int PATTERN_MAX = 8;
   localparam int REPLACE_MAX = 8;

   // Largest burst a single command may carry
   localparam int BUF_BYTES = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
   localparam int DATA_W    = 8 * BUF_BYTES;
   localparam int CNT_W     = $clog2(BUF_BYTES + 1);
   localparam int IDX_W     = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;

   // Configuration port
   localparam int CFG_W     = 64;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_BYTES = 2'd3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One command: emit cnt bytes of data (lowest byte first); last marks end of text.
   // cnt of zero with last set is a bare end mark.
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  cnt;
      logic              last;
   } sfr_cmd_type;

endpackage

`default_nettype wire

[hdl/stream_find_replace_core.sv]
// Top level of the stream find-and-replace block.
`default_nettype none

// Replaces each non-overlapping occurrence of a configured pattern (up to eight
// bytes) in a byte stream with a configured replacement (up to eight bytes).
// One source byte is taken per cycle while the command queue has room. Results
// leave one per cycle through an output register while the receiver pops, so a
// byte that causes a single result flows at full rate; a match causes
// replace_len results and the end of text flushes the pending window, and those
// bursts are absorbed by a four-entry command queue between the matcher and the
// output sequencer. req_full rises once that queue fills, which paces source
// bytes to the results. A match needs the whole pattern, so up to
// pattern_len - 1 bytes stay pending until later bytes or the last mark release
// them. Configuration must be written while the stream is idle (unchecked).

module stream_find_replace_core
   import sfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic                 req_push,
   output logic                      req_full,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_in_last,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_has_byte,
   output logic                      rsp_out_last
);

   logic        accept;
   logic        cmd_push;
   sfr_cmd_type cmd;
   logic        q_full;
   logic        q_valid;
   sfr_cmd_type q_head;
   logic        q_pop;

   // Take a byte whenever the command queue has room
   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   sfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .in_byte   (req_in_byte),
      .in_last   (req_in_last),
      .cmd_push  (cmd_push),
      .cmd       (cmd)
   );

   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (q_full),
      .valid    (q_valid),
      .head     (q_head),
      .pop      (q_pop)
   );

   sfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

`default_nettype wire

[hdl/sfr_front.sv]
// Front end: configuration registers, match window and per-byte command generation.
`default_nettype none

module sfr_front
   import sfr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata,
   input  wire logic                  accept,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_last,
   output logic                       cmd_push,
   output sfr_cmd_type                cmd
);

   logic [LEN_W-1:0] pattern_len_ff;
   logic [CFG_W-1:0] pattern_bytes_ff;
   logic [LEN_W-1:0] replace_len_ff;
   logic [CFG_W-1:0] replace_bytes_ff;

   logic [7:0]       win_ff [PATTERN_MAX];
   logic [7:0]       win_in [PATTERN_MAX];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   logic [7:0]       w [PATTERN_MAX];
   logic [CNT_W-1:0] plen;
   logic [CNT_W-1:0] rlen;
   logic [CNT_W-1:0] fill;
   logic             hit;
   logic             match;
   logic             pop;
   logic [DATA_W-1:0] win_data;
   logic [DATA_W-1:0] rep_data;

   // Byte k of a configuration word; bytes past the word read as zero
   function automatic logic [7:0] byte_of(input logic [CFG_W-1:0] word, input int k);
      logic [CFG_W-1:0] t;
      t = word >> (8 * k);
      return (k >= CFG_W / 8) ? 8'd0 : t[7:0];
   endfunction

   // Saturate configured lengths
   always_comb begin
      plen = (32'(pattern_len_ff) > PATTERN_MAX) ? CNT_W'(PATTERN_MAX) : CNT_W'(pattern_len_ff);
      rlen = (32'(replace_len_ff) > REPLACE_MAX) ? CNT_W'(REPLACE_MAX) : CNT_W'(replace_len_ff);
   end

   // Insert the new byte, test the window, build the command
   always_comb begin
      fill = cnt_ff + CNT_W'(1);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         w[i] = (CNT_W'(i) == cnt_ff) ? in_byte : win_ff[i];
      end

      hit = 1'b1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (CNT_W'(k) < plen && w[k] != byte_of(pattern_bytes_ff, k)) begin
            hit = 1'b0;
         end
      end
      match = (fill == plen) && hit;
      pop   = (fill > plen) || ((fill == plen) && !hit);

      win_data = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_data[8*i +: 8] = w[i];
      end
      rep_data = '0;
      for (int k = 0; k < REPLACE_MAX; k++) begin
         rep_data[8*k +: 8] = byte_of(replace_bytes_ff, k);
      end

      cmd.last = in_last;
      if (match) begin
         cmd.data = rep_data;
         cmd.cnt  = rlen;
      end else begin
         cmd.data = win_data;
         if (in_last) begin
            cmd.cnt = fill;
         end else if (pop) begin
            cmd.cnt = CNT_W'(1);
         end else begin
            cmd.cnt = '0;
         end
      end
      cmd_push = accept && (cmd.cnt != '0 || in_last);

      // Next window: clear on match or end of text, drop oldest on a pop
      for (int i = 0; i < PATTERN_MAX; i++) begin
         win_in[i] = (pop && i + 1 < PATTERN_MAX) ? w[(i + 1) % PATTERN_MAX] : w[i];
      end
      if (match || in_last) begin
         cnt_in = '0;
      end else if (pop) begin
         cnt_in = fill - CNT_W'(1);
      end else begin
         cnt_in = fill;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff   <= '0;
         pattern_bytes_ff <= '0;
         replace_len_ff   <= '0;
         replace_bytes_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LEN:   pattern_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_BYTES: pattern_bytes_ff <= csr_wdata;
            CSR_REPLACE_LEN:   replace_len_ff   <= csr_wdata[LEN_W-1:0];
            CSR_REPLACE_BYTES: replace_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Window fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // Window bytes
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      accept && in_last |=> cnt_ff == '0)
      else $error("window not empty after end of text");

   a_bare_mark_last: assert property (@(posedge clock) disable iff (reset)
      cmd_push && cmd.cnt == '0 |-> cmd.last)
      else $error("empty command without end mark");

endmodule

`default_nettype wire

[hdl/sfr_queue.sv]
// Command queue that decouples the front end from the output sequencer.
`default_nettype none

module sfr_queue
   import sfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire sfr_cmd_type push_cmd,
   output logic             full,
   output logic             valid,
   output sfr_cmd_type      head,
   input  wire logic        pop
);

   sfr_cmd_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (cnt_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("command queue underflow");

endmodule

`default_nettype wire

[hdl/sfr_back.sv]
// Output sequencer: expands queued commands into single-byte results.
`default_nettype none

module sfr_back
   import sfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire sfr_cmd_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_out_last
);

   logic [IDX_W-1:0] idx_ff;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_out_byte_ff;
   logic             rsp_has_byte_ff;
   logic             rsp_out_last_ff;

   logic             out_ready;
   logic             emit;
   logic             done;
   logic             has;

   // Pick the next byte of the head command
   always_comb begin
      out_ready = !rsp_valid_ff || rsp_pop;
      emit      = q_valid && out_ready;
      has       = (q_head.cnt != '0);
      done      = !has || (CNT_W'(idx_ff) + CNT_W'(1) == q_head.cnt);
      q_pop     = emit && done;
   end

   // Walk through the bytes of the head command
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (emit) begin
         idx_ff <= done ? '0 : idx_ff + IDX_W'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_out_byte_ff <= has ? q_head.data[{idx_ff, 3'b000} +: 8] : 8'd0;
         rsp_has_byte_ff <= has;
         rsp_out_last_ff <= q_head.last && done;
      end
   end

   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_has_byte = rsp_has_byte_ff;
   assign rsp_out_last = rsp_out_last_ff;

   a_mark_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_byte_ff |-> rsp_out_last_ff)
      else $error("bare end mark without last");

endmodule

`default_nettype wire

[bench/sfr_rewrite_checker.sv]
// Checker for the stream find-and-replace block: predicts and compares rewritten results.
`timescale 1ns / 100ps

module sfr_rewrite_checker
   import sfr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   input  wire logic                 req_push,
   input  wire logic                 req_full,
   input  wire logic [7:0]           req_in_byte,
   input  wire logic                 req_in_last,
   input  wire logic                 rsp_empty,
   input  wire logic                 rsp_pop,
   input  wire logic [7:0]           rsp_out_byte,
   input  wire logic                 rsp_has_byte,
   input  wire logic                 rsp_out_last,
   output int                        fail_count,
   output int                        outstanding
);

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic       last;
   } out_beat_type;

   out_beat_type     rewritten_q[$];
   logic [LEN_W-1:0] pat_len_r;
   logic [LEN_W-1:0] rep_len_r;
   logic [CFG_W-1:0] pat_r;
   logic [CFG_W-1:0] rep_r;
   logic [7:0]       window [PATTERN_MAX];
   int               win_fill;
   int               fails;

   assign fail_count = fails;

   initial begin
      fails = 0;
      outstanding = 0;
   end

   task automatic flag_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fails++;
   endtask

   function automatic logic [7:0] take_oldest();
      logic [7:0] b;
      b = window[0];
      for (int k = 1; k < PATTERN_MAX; k++) window[k-1] = window[k];
      win_fill--;
      return b;
   endfunction

   task automatic queue_beat(input logic [7:0] b, input logic has);
      out_beat_type beat;
      beat.data = b;
      beat.has  = has;
      beat.last = 1'b0;
      rewritten_q.push_back(beat);
   endtask

   // Advance the window by one source byte and queue the results it releases
   task automatic rewrite_byte(input logic [7:0] b, input logic last);
      int           plen;
      int           rlen;
      int           made;
      bit           hit;
      out_beat_type tail;
      plen = (pat_len_r > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_r);
      rlen = (rep_len_r > REPLACE_MAX) ? REPLACE_MAX : int'(rep_len_r);
      made = 0;
      window[win_fill] = b;
      win_fill++;
      if (win_fill > plen) begin
         // window too long (zero or shortened pattern): release oldest, no test
         queue_beat(take_oldest(), 1'b1);
         made++;
      end else if (win_fill == plen) begin
         hit = 1'b1;
         for (int k = 0; k < plen; k++) begin
            if (window[k] != pat_r[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            for (int k = 0; k < rlen; k++) queue_beat(rep_r[8*k +: 8], 1'b1);
            made += rlen;
            win_fill = 0;
         end else begin
            queue_beat(take_oldest(), 1'b1);
            made++;
         end
      end
      if (last) begin
         // flush the window; a text end that yields nothing gets a bare end mark
         while (win_fill > 0) begin
            queue_beat(take_oldest(), 1'b1);
            made++;
         end
         if (made == 0) queue_beat(8'h00, 1'b0);
         tail = rewritten_q.pop_back();
         tail.last = 1'b1;
         rewritten_q.push_back(tail);
      end
   endtask

   // Compare one result transfer against the oldest expectation
   task automatic check_result();
      out_beat_type want;
      if (rewritten_q.size() == 0) begin
         flag_mismatch($sformatf("unexpected result byte %02h has %0d last %0d",
                                 rsp_out_byte, rsp_has_byte, rsp_out_last));
      end else begin
         want = rewritten_q.pop_front();
         if (rsp_out_byte !== want.data || rsp_has_byte !== want.has ||
             rsp_out_last !== want.last) begin
            flag_mismatch($sformatf("got byte %02h has %0d last %0d, want %02h %0d %0d",
                                    rsp_out_byte, rsp_has_byte, rsp_out_last,
                                    want.data, want.has, want.last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_len_r = '0;
         rep_len_r = '0;
         pat_r     = '0;
         rep_r     = '0;
         win_fill  = 0;
         rewritten_q.delete();
      end else begin
         // check results before predicting: a result never stems from a same-edge transfer
         if (rsp_pop && !rsp_empty) check_result();
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_LEN:   pat_len_r = csr_wdata[LEN_W-1:0];
               CSR_PATTERN_BYTES: pat_r     = csr_wdata;
               CSR_REPLACE_LEN:   rep_len_r = csr_wdata[LEN_W-1:0];
               CSR_REPLACE_BYTES: rep_r     = csr_wdata;
               default: ;
            endcase
         end
         if (req_push && !req_full) rewrite_byte(req_in_byte, req_in_last);
      end
      outstanding <= rewritten_q.size();
   end

endmodule

[bench/tb_top.sv]
// Testbench top for the stream find-and-replace block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_top;
   import sfr_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int HOLD_CYCLES   = 120;
   localparam int RAND_PHASES   = 12;
   localparam int PHASE_BYTES   = 40;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   logic                 req_push;
   logic                 req_full;
   logic [7:0]           req_in_byte;
   logic                 req_in_last;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_has_byte;
   logic                 rsp_out_last;
   int                   fail_count;
   int                   outstanding;

   int                   burst_left;
   int                   hold_asks;
   int                   hold_done;

   stream_find_replace_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last)
   );

   sfr_rewrite_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last),
      .fail_count   (fail_count),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bound the run in case the block hangs
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Write all four registers back to back
   task automatic write_config(input logic [LEN_W-1:0] plen, input logic [CFG_W-1:0] pat,
                               input logic [LEN_W-1:0] rlen, input logic [CFG_W-1:0] rep);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PATTERN_LEN;
      csr_wdata <= CFG_W'(plen);
      @(posedge clock);
      csr_index <= CSR_PATTERN_BYTES;
      csr_wdata <= pat;
      @(posedge clock);
      csr_index <= CSR_REPLACE_LEN;
      csr_wdata <= CFG_W'(rlen);
      @(posedge clock);
      csr_index <= CSR_REPLACE_BYTES;
      csr_wdata <= rep;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offer one source byte; hold push across bursts, drop it for a random gap
   task automatic send_byte(input logic [7:0] b, input logic last);
      int pause;
      req_push    <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 10);
         pause = $urandom_range(1, 8);
         req_push <= 1'b0;
         repeat (pause) @(posedge clock);
      end
   endtask

   // Wait until every expected result has left, then let the pipeline settle
   task automatic drain_and_settle();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Receiver: runs of pops broken by short stalls, plus long hold-offs on request
   initial begin
      int run;
      int stall;
      rsp_pop = 1'b0;
      hold_done = 0;
      @(negedge reset);
      forever begin
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         run = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
         rsp_pop <= 1'b1;
         repeat (run) @(posedge clock);
         stall = $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      logic [LEN_W-1:0] plen;
      logic [LEN_W-1:0] rlen;
      logic [CFG_W-1:0] pat;
      logic [CFG_W-1:0] rep;
      logic [7:0]       sym_a;
      logic [7:0]       sym_b;
      int               plen_eff;
      int               sent;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_PATTERN_LEN;
      csr_wdata   = '0;
      req_push    = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      burst_left  = 0;
      hold_asks   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: zero-length pattern passes bytes through
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_and_settle();

      // Two-byte pattern, three-byte replacement: match, near miss, flush of a partial
      write_config(4'd2, 64'h4241, 4'd3, 64'h7A7978);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b1);
      drain_and_settle();

      // Pattern of one 00h byte, empty replacement: text ending in a match gives a bare end mark
      write_config(4'd1, 64'h0, 4'd0, 64'h0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
      drain_and_settle();

      // Oversized lengths saturate; leave a partial match pending at the end
      write_config(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0);
      repeat (8) send_byte(8'hFF, 1'b0);
      repeat (3) send_byte(8'hFF, 1'b0);
      drain_and_settle();

      // Shorten the pattern while bytes are pending
      write_config(4'd1, 64'hAA, 4'd8, 64'h0123_4567_89AB_CDEF);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain_and_settle();

      // Random phases: random configuration, text rich in the pattern and its bytes
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         plen = LEN_W'($urandom_range(0, 9));
         if (plen == 9) plen = LEN_W'($urandom_range(9, 15));
         rlen = LEN_W'($urandom_range(0, 9));
         if (rlen == 9) rlen = LEN_W'($urandom_range(9, 15));
         pat = {$urandom, $urandom};
         rep = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 1) begin
            // two-symbol pattern makes overlapping partial matches likely
            sym_a = 8'($urandom);
            sym_b = 8'($urandom);
            for (int k = 0; k < 8; k++) pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
         end
         plen_eff = (plen > PATTERN_MAX) ? PATTERN_MAX : int'(plen);
         write_config(plen, pat, rlen, rep);
         if (phase == 3 || phase == 8) hold_asks++;
         sent = 0;
         while (sent < PHASE_BYTES) begin
            if (plen_eff > 0 && $urandom_range(0, 3) == 0) begin
               for (int k = 0; k < plen_eff; k++) send_byte(pat[8*k +: 8], 1'b0);
               sent += plen_eff;
            end else if ($urandom_range(0, 1) == 1) begin
               send_byte(pat[8*$urandom_range(0, 7) +: 8], $urandom_range(0, 15) == 0);
               sent++;
            end else begin
               send_byte(8'($urandom), $urandom_range(0, 15) == 0);
               sent++;
            end
         end
         // mostly close the text; sometimes leave it open across the next configuration
         send_byte(8'($urandom), $urandom_range(0, 3) != 0);
         drain_and_settle();
      end

      // Close any open text so the window is flushed
      send_byte(8'($urandom), 1'b1);
      drain_and_settle();

      if (fail_count == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
